// ===== src/scpu_pkg.sv =====
// Shared types, opcodes and constants of the small CPU execute unit.
`timescale 1ns / 1ps

package scpu_pkg;

    // Default data memory size in bytes (a power of two).
    localparam int unsigned MEM_BYTES_DEF = 32768;

    // Depth of the result queue; it also bounds the number of beats in flight.
    localparam int unsigned OUT_DEPTH = 4;

    // Bus widths of the two streams.
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 136;

    // Opcodes of the decoded instruction.
    typedef enum logic [3:0] {
        OP_MOVI  = 4'd0,
        OP_MOVR  = 4'd1,
        OP_LOAD  = 4'd2,
        OP_STORE = 4'd3,
        OP_CMP   = 4'd4,
        OP_JMP   = 4'd5,
        OP_JG    = 4'd6,
        OP_JL    = 4'd7,
        OP_JE    = 4'd8,
        OP_ADD   = 4'd9,
        OP_SUB   = 4'd10,
        OP_AND   = 4'd11,
        OP_OR    = 4'd12,
        OP_XOR   = 4'd13,
        OP_SAL   = 4'd14,
        OP_SAR   = 4'd15
    } op_t;

    // Compare flags.
    typedef struct packed {
        logic greater;
        logic less;
        logic equal;
    } flags_t;

    // One result beat; the last member lands in the lowest bits.
    typedef struct packed {
        logic [31:0] op_count;
        logic        flag_equal;
        logic        flag_less;
        logic        flag_greater;
        logic [31:0] dest_value;
        logic [3:0]  dest_index;
        logic        dest_written;
        logic [31:0] next_pc;
        logic [31:0] instr_pc;
    } out_beat_t;

    // Sign-extend a 16-bit immediate to 32 bits.
    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

// ===== src/small_cpu_instruction_execute_unit.sv =====
// Execute stage of a 16-register, 32-bit machine with byte-addressed data memory.
`timescale 1ns / 1ps

// The unit executes one decoded instruction per input beat and returns one result
// beat per instruction, in order. It sustains one instruction per cycle while
// s_tready is high: a beat accepted at one edge reads the register file, executes
// and addresses the data memory in the next cycle, and completes loads and the
// register write-back in the cycle after that; its result beat shows on m_tvalid
// once it enters the result queue. Results of the two preceding instructions are
// forwarded, so back-to-back dependent instructions, including load-use, run
// without stalls. Completed results wait in a four-beat queue, and s_tready drops
// only when that queue and the two stages together hold four beats, or after reset
// while the data memory is cleared one 32-bit row per cycle.
// MEM_BYTES must be a power of two; byte addresses wrap modulo MEM_BYTES.
module small_cpu_instruction_execute_unit
    import scpu_pkg::*;
#(
    parameter int unsigned MEM_BYTES = MEM_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // operation[3:0], reg_x[7:4], reg_y[11:8], imm_field[27:12], zero[31:28]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // instr_pc[31:0], next_pc[63:32], dest_written[64], dest_index[68:65],
    // dest_value[100:69], flag_greater[101], flag_less[102], flag_equal[103],
    // op_count[135:104]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int unsigned ADDR_W = $clog2(MEM_BYTES);
    localparam int unsigned ROWS   = MEM_BYTES / 4;
    localparam int unsigned ROW_W  = ADDR_W - 2;
    localparam int unsigned PTR_W  = $clog2(OUT_DEPTH);
    localparam int unsigned CNT_W  = $clog2(OUT_DEPTH + 1);
    localparam int unsigned OCC_W  = CNT_W + 1;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [OCC_W-1:0] OCC_MAX  = OCC_W'(OUT_DEPTH);

    // Input beat fields.
    op_t         in_op;
    logic [3:0]  in_rx;
    logic [3:0]  in_ry;
    logic [15:0] in_imm;
    logic        s_fire;

    assign in_op  = op_t'(s_tdata[3:0]);
    assign in_rx  = s_tdata[7:4];
    assign in_ry  = s_tdata[11:8];
    assign in_imm = s_tdata[27:12];
    assign s_fire = s_tvalid && s_tready;

    // Architectural state outside the memories.
    logic [31:0] pc_reg;
    flags_t      flags_reg;
    logic [31:0] opc_reg [16];

    // Data memory clearing pass after reset.
    logic             clr_active_reg;
    logic [ROW_W-1:0] clr_row_reg;

    // Register file: two synchronous read ports, one write port, valid bits.
    logic [31:0] rf_mem [16];
    logic [15:0] rf_vld_reg;
    logic [31:0] rf_x_reg;
    logic [31:0] rf_y_reg;
    logic        rf_xv_reg;
    logic        rf_yv_reg;

    // Execute stage.
    logic        s1_valid_reg;
    op_t         s1_op_reg;
    logic [3:0]  s1_rx_reg;
    logic [3:0]  s1_ry_reg;
    logic [15:0] s1_imm_reg;

    // Write-back stage.
    logic        s2_valid_reg;
    logic        s2_load_reg;
    logic        s2_wr_reg;
    logic [3:0]  s2_rx_reg;
    logic [31:0] s2_alu_reg;
    logic [1:0]  s2_off_reg;
    logic [31:0] s2_pc_reg;
    logic [31:0] s2_next_reg;
    flags_t      s2_flags_reg;
    logic [31:0] s2_count_reg;

    // Most recent register write, for the read that coincides with it.
    logic        wb_valid_reg;
    logic [3:0]  wb_idx_reg;
    logic [31:0] wb_val_reg;

    // Data memory banks, one byte lane each.
    logic [ROW_W-1:0] bank_addr [4];
    logic             bank_we [4];
    logic [7:0]       bank_wdata [4];
    logic [7:0]       bank_rdata_reg [4];

    // Result queue.
    out_beat_t        fifo_mem [OUT_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] fifo_cnt_reg;

    // Combinational signals of the execute stage.
    logic [31:0]       vx;
    logic [31:0]       vy;
    logic [31:0]       offs;
    logic [7:0]        shamt;
    logic [31:0]       alu_res;
    logic              alu_wr;
    logic              taken;
    logic [31:0]       next_pc;
    flags_t            flags_next;
    logic [31:0]       count_next;
    logic [ADDR_W-1:0] mem_addr;
    logic [ROW_W-1:0]  mem_row;
    logic [1:0]        mem_off;

    // Combinational signals of the write-back stage.
    logic [31:0] ld_word;
    logic [31:0] s2_res;
    logic        s2_we;
    out_beat_t   s2_beat;

    logic [OCC_W-1:0] occ;
    logic             m_fire;

    // Register file read at acceptance and write at write-back.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rf_x_reg  <= rf_mem[in_rx];
            rf_y_reg  <= rf_mem[in_ry];
            rf_xv_reg <= rf_vld_reg[in_rx];
            rf_yv_reg <= rf_vld_reg[in_ry];
        end
        if (s2_we) begin
            rf_mem[s2_rx_reg] <= s2_res;
        end
    end

    // Register valid bits and the last-write record.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rf_vld_reg   <= '0;
            wb_valid_reg <= 1'b0;
        end else if (s2_we) begin
            rf_vld_reg[s2_rx_reg] <= 1'b1;
            wb_valid_reg          <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_we) begin
            wb_idx_reg <= s2_rx_reg;
            wb_val_reg <= s2_res;
        end
    end

    // Operand forwarding: write-back stage first, then the last completed write.
    always_comb begin
        if (s2_we && s2_rx_reg == s1_rx_reg) begin
            vx = s2_res;
        end else if (wb_valid_reg && wb_idx_reg == s1_rx_reg) begin
            vx = wb_val_reg;
        end else begin
            vx = rf_xv_reg ? rf_x_reg : 32'd0;
        end
        if (s2_we && s2_rx_reg == s1_ry_reg) begin
            vy = s2_res;
        end else if (wb_valid_reg && wb_idx_reg == s1_ry_reg) begin
            vy = wb_val_reg;
        end else begin
            vy = rf_yv_reg ? rf_y_reg : 32'd0;
        end
    end

    // Execute: ALU, compare, branch decision and counter increment.
    assign offs  = sext16(s1_imm_reg);
    assign shamt = s1_imm_reg[15:8];

    always_comb begin
        alu_res    = 32'd0;
        alu_wr     = 1'b0;
        taken      = 1'b0;
        flags_next = flags_reg;
        unique case (s1_op_reg)
            OP_MOVI: begin
                alu_res = offs;
                alu_wr  = 1'b1;
            end
            OP_MOVR: begin
                alu_res = vy;
                alu_wr  = 1'b1;
            end
            OP_LOAD: begin
                alu_wr = 1'b1;
            end
            OP_STORE: begin
                alu_wr = 1'b0;
            end
            OP_CMP: begin
                flags_next.greater = $signed(vx) > $signed(vy);
                flags_next.less    = $signed(vx) < $signed(vy);
                flags_next.equal   = vx == vy;
            end
            OP_JMP: taken = 1'b1;
            OP_JG:  taken = flags_reg.greater;
            OP_JL:  taken = flags_reg.less;
            OP_JE:  taken = flags_reg.equal;
            OP_ADD: begin
                alu_res = vx + vy;
                alu_wr  = 1'b1;
            end
            OP_SUB: begin
                alu_res = vx - vy;
                alu_wr  = 1'b1;
            end
            OP_AND: begin
                alu_res = vx & vy;
                alu_wr  = 1'b1;
            end
            OP_OR: begin
                alu_res = vx | vy;
                alu_wr  = 1'b1;
            end
            OP_XOR: begin
                alu_res = vx ^ vy;
                alu_wr  = 1'b1;
            end
            OP_SAL: begin
                alu_res = vx << shamt;
                alu_wr  = 1'b1;
            end
            OP_SAR: begin
                alu_res = 32'($signed(vx) >>> shamt);
                alu_wr  = 1'b1;
            end
        endcase
    end

    assign next_pc    = pc_reg + 32'd4 + (taken ? offs : 32'd0);
    assign count_next = opc_reg[s1_op_reg] + 32'd1;

    // Memory address: loads use reg_y, stores use reg_x; wraps at MEM_BYTES.
    assign mem_addr = (s1_op_reg == OP_LOAD) ? vy[ADDR_W-1:0] : vx[ADDR_W-1:0];
    assign mem_row  = mem_addr[ADDR_W-1:2];
    assign mem_off  = mem_addr[1:0];

    // Architectural registers updated in the execute stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg    <= 32'd0;
            flags_reg <= '0;
            for (int i = 0; i < 16; i++) begin
                opc_reg[i] <= 32'd0;
            end
        end else if (s1_valid_reg) begin
            pc_reg             <= next_pc;
            flags_reg          <= flags_next;
            opc_reg[s1_op_reg] <= count_next;
        end
    end

    // Memory clearing pass, one row of all four banks per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_row_reg    <= '0;
        end else if (clr_active_reg) begin
            clr_row_reg <= clr_row_reg + ROW_W'(1);
            if (clr_row_reg == LAST_ROW) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Byte lanes: lane b holds word byte (b - off) and rolls to the next row
    // when it lies below the start offset.
    for (genvar b = 0; b < 4; b++) begin : gen_bank
        logic [7:0] mem [ROWS];
        logic [1:0] lane;

        assign lane = 2'(b) - mem_off;

        always_comb begin
            if (clr_active_reg) begin
                bank_addr[b]  = clr_row_reg;
                bank_we[b]    = 1'b1;
                bank_wdata[b] = 8'd0;
            end else begin
                bank_addr[b]  = mem_row + ROW_W'(2'(b) < mem_off);
                bank_we[b]    = s1_valid_reg && (s1_op_reg == OP_STORE);
                bank_wdata[b] = vy[8*lane +: 8];
            end
        end

        always_ff @(posedge aclk) begin
            if (bank_we[b]) begin
                mem[bank_addr[b]] <= bank_wdata[b];
            end
            bank_rdata_reg[b] <= mem[bank_addr[b]];
        end
    end

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_fire;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_op_reg  <= in_op;
            s1_rx_reg  <= in_rx;
            s1_ry_reg  <= in_ry;
            s1_imm_reg <= in_imm;
        end
        if (s1_valid_reg) begin
            s2_load_reg  <= s1_op_reg == OP_LOAD;
            s2_wr_reg    <= alu_wr;
            s2_rx_reg    <= s1_rx_reg;
            s2_alu_reg   <= alu_res;
            s2_off_reg   <= mem_off;
            s2_pc_reg    <= pc_reg;
            s2_next_reg  <= next_pc;
            s2_flags_reg <= flags_next;
            s2_count_reg <= count_next;
        end
    end

    // Write-back: gather the loaded word in little-endian order.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            ld_word[8*k +: 8] = bank_rdata_reg[2'(k) + s2_off_reg];
        end
    end

    assign s2_res = s2_load_reg ? ld_word : s2_alu_reg;
    assign s2_we  = s2_valid_reg && s2_wr_reg;

    always_comb begin
        s2_beat.instr_pc     = s2_pc_reg;
        s2_beat.next_pc      = s2_next_reg;
        s2_beat.dest_written = s2_wr_reg;
        s2_beat.dest_index   = s2_wr_reg ? s2_rx_reg : 4'd0;
        s2_beat.dest_value   = s2_wr_reg ? s2_res : 32'd0;
        s2_beat.flag_greater = s2_flags_reg.greater;
        s2_beat.flag_less    = s2_flags_reg.less;
        s2_beat.flag_equal   = s2_flags_reg.equal;
        s2_beat.op_count     = s2_count_reg;
    end

    // Result queue.
    assign m_fire = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            fifo_mem[wr_ptr_reg] <= s2_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (s2_valid_reg) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (m_fire) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            fifo_cnt_reg <= fifo_cnt_reg + CNT_W'(s2_valid_reg) - CNT_W'(m_fire);
        end
    end

    assign m_tvalid = fifo_cnt_reg != '0;
    assign m_tdata  = fifo_mem[rd_ptr_reg];

    // Admit a beat only when the queue has room for everything in flight.
    assign occ      = OCC_W'(fifo_cnt_reg) + OCC_W'(s1_valid_reg) + OCC_W'(s2_valid_reg);
    assign s_tready = !clr_active_reg && (occ < OCC_MAX);

endmodule

// ===== src/scpu_checker.sv =====
// Port-level checks of the small CPU execute unit and their binding.
`timescale 1ns / 1ps

module scpu_checker
    import scpu_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    out_beat_t beat;
    logic      have_prev_reg;
    logic [31:0] prev_next_reg;

    assign beat = m_tdata;

    // Remember where the previous result beat said execution continues.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            have_prev_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            prev_next_reg <= beat.next_pc;
        end
    end

    // Nothing is presented in the cycle after reset.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat presented right after reset");

    // A stalled result beat holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // Each instruction starts where the previous one said to continue.
    a_pc_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && have_prev_reg |-> beat.instr_pc == prev_next_reg)
        else $error("instr_pc does not follow previous next_pc");

    // Without a register write the destination fields are zero.
    a_no_dest: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !beat.dest_written |-> beat.dest_index == 4'd0 && beat.dest_value == 32'd0)
        else $error("destination fields set without a register write");

    // A compare sets at most one flag.
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $countones({beat.flag_greater, beat.flag_less, beat.flag_equal}) <= 1)
        else $error("more than one compare flag set");

endmodule

bind small_cpu_instruction_execute_unit scpu_checker u_scpu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
